// File: src/sgc_pkg.sv
// Shared types and constants for the strain gauge conditioner.
// Used by the controller, the divider, the datapath and the top level.
package sgc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int WIN_W    = 7;
    localparam int SUM_W    = SAMPLE_W + WIN_W;
    localparam int AVG_W    = 20;
    localparam int ACC_W    = 36;
    localparam int TCNT_W   = 16;
    localparam int MARGIN_W = 12;
    localparam int CFG_DW   = 32;
    localparam int CFG_AW   = 3;
    localparam int DIV_W    = ACC_W;
    localparam int DIVS_W   = TCNT_W;
    localparam int STEP_W   = 6;
    localparam int PROD_W   = AVG_W + 1 + CFG_DW;

    localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(SUM_W + 8);
    localparam logic [STEP_W-1:0] TARE_STEPS = STEP_W'(DIV_W);
    localparam logic [AVG_W-1:0]  AVG_MAX    = 20'hFFF00;

    localparam logic [CFG_AW-1:0] REG_WINDOW     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SLOPE      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_INTERCEPT  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TARE_COUNT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SAT_MARGIN = 3'd4;

    typedef struct packed {
        logic accept;      // latch a sample request and read the ring slot
        logic tare_start;  // clear the filter and arm the tare
        logic push;        // update ring, sum, fill and position
        logic div_start;
        logic div_long;    // tare division instead of average division
        logic avg_load;
        logic tare_step;
        logic tare_load;
        logic mul;
        logic add;
        logic fin;         // load the output register
    } sgc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic tare_active;
        logic tare_last;
        logic out_free;
    } sgc_status_t;

endpackage

// File: src/sgc_ctrl.sv
// Sequencing controller for the strain gauge conditioner.
// Depends on sgc_pkg for the command and status structs.
module sgc_ctrl
    import sgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_kind,
    output logic        in_ready,
    input  sgc_status_t st,
    output sgc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_DIVA_GO,
        S_DIVA,
        S_TARE,
        S_DIVT_GO,
        S_DIVT,
        S_MUL,
        S_ADD,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept     = ~in_kind;
                    cmd.tare_start = in_kind;
                    state_next     = in_kind ? S_MUL : S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_DIVA_GO;
            end
            S_DIVA_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVA;
            end
            S_DIVA:
            begin
                if (st.div_done)
                begin
                    cmd.avg_load = 1'b1;
                    state_next   = st.tare_active ? S_TARE : S_MUL;
                end
            end
            S_TARE:
            begin
                cmd.tare_step = 1'b1;
                state_next    = st.tare_last ? S_DIVT_GO : S_MUL;
            end
            S_DIVT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_long  = 1'b1;
                state_next    = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.div_long = 1'b1;
                if (st.div_done)
                begin
                    cmd.tare_load = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Wait here only while an older result is still unclaimed.
                if (st.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/sgc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the average and tare paths.
// Depends on sgc_pkg for widths and step counts.
module sgc_div
    import sgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              long_div,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [AVG_W-1:0]  quotient
);

    localparam int SHORT_W = SUM_W + 8;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIVS_W:0]   rem_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W:0]   shifted;
    logic              fits;

    assign shifted  = {rem_reg[DIVS_W-1:0], q_reg[DIV_W-1]};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg[AVG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= long_div ? TARE_STEPS : AVG_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            // A short division starts with its dividend left-aligned.
            q_reg   <= long_div ? dividend
                                : {dividend[SHORT_W-1:0], {(DIV_W-SHORT_W){1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

endmodule

// File: src/sgc_datapath.sv
// Datapath: configuration registers, sample ring, running sum, tare, calibration and
// output register. Depends on sgc_pkg and instantiates sgc_div.
module sgc_datapath
    import sgc_pkg::*;
#(
    parameter int RING_SLOTS = 64,
    parameter int ADC_BITS   = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_wr_index,
    input  logic [CFG_DW-1:0]   cfg_wr_data,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [AVG_W-1:0]    out_avg,
    output logic [CFG_DW-1:0]   out_units,
    output logic                out_sat_high,
    output logic                out_sat_low,
    output logic                out_taring,
    input  sgc_cmd_t            cmd,
    output sgc_status_t         st
);

    localparam int AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int PW = AW + 1;
    localparam logic [SAMPLE_W-1:0] CODE_MASK = SAMPLE_W'((32'd1 << ADC_BITS) - 32'd1);
    localparam logic [16:0] FULL_SCALE = 17'((32'd1 << ADC_BITS) - 32'd1);
    localparam logic signed [45:0] UNITS_MAX = 46'sh0_7FFF_FFFF;
    localparam logic signed [45:0] UNITS_MIN = -46'sh0_8000_0000;

    // Configuration
    logic [WIN_W-1:0]         win_reg;
    logic signed [CFG_DW-1:0] slope_reg;
    logic signed [CFG_DW-1:0] icpt_reg;
    logic [TCNT_W-1:0]        tcnt_reg;
    logic [MARGIN_W-1:0]      margin_reg;
    logic [WIN_W-1:0]         win_wr;

    // Filter and tare state
    logic [SAMPLE_W-1:0] ring_mem [RING_SLOTS];
    logic [SAMPLE_W-1:0] code_reg;
    logic [SAMPLE_W-1:0] old_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [AW-1:0]       pos_reg;
    logic [WIN_W-1:0]    fill_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [AVG_W-1:0]    tare_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [TCNT_W-1:0]   left_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic [CFG_DW-1:0]        units_reg;
    logic                     valid_reg;

    logic                full;
    logic [PW-1:0]       pos_inc;
    logic [TCNT_W-1:0]   tare_div;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIVS_W-1:0]   div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [AVG_W-1:0]    div_q;
    logic signed [AVG_W:0]  diff;
    logic signed [45:0]     units_sum;
    logic signed [17:0]     high_lim;

    always_comb
    begin
        win_wr = cfg_wr_data[WIN_W-1:0];
        if (win_wr == '0)
        begin
            win_wr = WIN_W'(1);
        end
        else if (32'(win_wr) > RING_SLOTS)
        begin
            win_wr = WIN_W'(RING_SLOTS);
        end
    end

    assign full     = (fill_reg == win_reg);
    assign pos_inc  = {1'b0, pos_reg} + PW'(1);
    assign tare_div = (tcnt_reg == '0) ? TCNT_W'(1) : tcnt_reg;

    assign div_dividend = cmd.div_long ? acc_reg
                                       : {{(DIV_W-SUM_W-8){1'b0}}, sum_reg, 8'b0};
    assign div_divisor  = cmd.div_long ? tare_div
                                       : {{(DIVS_W-WIN_W){1'b0}}, fill_reg};

    sgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .long_div (cmd.div_long),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign st.div_busy    = div_busy;
    assign st.div_done    = div_done;
    assign st.tare_active = (left_reg != '0);
    assign st.tare_last   = (left_reg == TCNT_W'(1));
    assign st.out_free    = ~valid_reg | out_ready;

    assign diff = $signed({1'b0, avg_reg}) - $signed({1'b0, tare_reg});

    // The arithmetic shift rounds toward minus infinity.
    assign units_sum = $signed({prod_reg[PROD_W-1], prod_reg[PROD_W-1:8]})
                     + 46'(icpt_reg);

    assign high_lim = $signed({1'b0, FULL_SCALE}) - $signed({6'b0, margin_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WIN_W'(16);
            slope_reg  <= 32'sd65536;
            icpt_reg   <= '0;
            tcnt_reg   <= TCNT_W'(1);
            margin_reg <= '0;
            sum_reg    <= '0;
            pos_reg    <= '0;
            fill_reg   <= '0;
            avg_reg    <= '0;
            tare_reg   <= '0;
            acc_reg    <= '0;
            left_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_wr_index)
                    REG_WINDOW:
                    begin
                        win_reg  <= win_wr;
                        sum_reg  <= '0;
                        pos_reg  <= '0;
                        fill_reg <= '0;
                        avg_reg  <= '0;
                    end
                    REG_SLOPE:      slope_reg  <= cfg_wr_data;
                    REG_INTERCEPT:  icpt_reg   <= cfg_wr_data;
                    REG_TARE_COUNT: tcnt_reg   <= cfg_wr_data[TCNT_W-1:0];
                    REG_SAT_MARGIN: margin_reg <= cfg_wr_data[MARGIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.tare_start)
            begin
                sum_reg  <= '0;
                pos_reg  <= '0;
                fill_reg <= '0;
                avg_reg  <= '0;
                acc_reg  <= '0;
                left_reg <= tare_div;
            end

            if (cmd.push)
            begin
                sum_reg <= sum_reg - (full ? SUM_W'(old_reg) : '0) + SUM_W'(code_reg);
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                pos_reg <= (pos_inc == PW'(win_reg)) ? '0 : pos_inc[AW-1:0];
            end

            if (cmd.avg_load)
            begin
                avg_reg <= div_q;
            end

            if (cmd.tare_step)
            begin
                acc_reg  <= acc_reg + ACC_W'(avg_reg);
                left_reg <= left_reg - 1'b1;
            end

            if (cmd.tare_load)
            begin
                tare_reg <= div_q;
            end

            if (cmd.fin)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Ring memory: one registered read at accept, one write when the sample is pushed.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            old_reg  <= ring_mem[pos_reg];
            code_reg <= in_sample & CODE_MASK;
        end
        if (cmd.push)
        begin
            ring_mem[pos_reg] <= code_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(diff) * PROD_W'(slope_reg);
        end
        if (cmd.add)
        begin
            if (units_sum > UNITS_MAX)
            begin
                units_reg <= 32'h7FFF_FFFF;
            end
            else if (units_sum < UNITS_MIN)
            begin
                units_reg <= 32'h8000_0000;
            end
            else
            begin
                units_reg <= units_sum[CFG_DW-1:0];
            end
        end
        if (cmd.fin)
        begin
            out_avg      <= avg_reg;
            out_units    <= units_reg;
            out_sat_high <= $signed({6'b0, avg_reg}) >= $signed({high_lim, 8'b0});
            out_sat_low  <= avg_reg <= {margin_reg, 8'b0};
            out_taring   <= (left_reg != '0);
        end
    end

    assign out_valid = valid_reg;

endmodule

// File: src/strain_gauge_conditioner_unit.sv
// Top level of the strain gauge conditioner: stream ports, configuration port,
// controller and datapath. Depends on sgc_pkg, sgc_ctrl and sgc_datapath.

// The block filters ADC codes with a moving average of up to RING_SLOTS samples and
// reports the average in Q12.8 codes, the tared and calibrated value in Q16.16 and
// saturation and taring flags, one result per request. It works on one request at a
// time; the shared divider produces one quotient bit per cycle over 27 bits for a
// sample. A sample taken while a tare is in progress passes through an extra tare
// step, the sample that completes a tare also runs the 36-bit tare division, and a
// tare-start request skips the divider. A new request is taken while the previous
// result still waits in the output register.
module strain_gauge_conditioner_unit
    import sgc_pkg::*;
#(
    parameter int RING_SLOTS = 64,
    parameter int ADC_BITS   = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_wr_index,
    input  logic [CFG_DW-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [11:0] sample, [15:12] zero
    input  logic              s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata    // [19:0] avg_code, [51:20] units, [52] sat_high,
                                         // [53] sat_low, [54] taring, [55] zero
);

    sgc_cmd_t          cmd;
    sgc_status_t       st;
    logic [AVG_W-1:0]  avg;
    logic [CFG_DW-1:0] units;
    logic              sat_high;
    logic              sat_low;
    logic              taring;

    sgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sgc_datapath #(
        .RING_SLOTS (RING_SLOTS),
        .ADC_BITS   (ADC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_sample    (s_tdata[SAMPLE_W-1:0]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_avg      (avg),
        .out_units    (units),
        .out_sat_high (sat_high),
        .out_sat_low  (sat_low),
        .out_taring   (taring),
        .cmd          (cmd),
        .st           (st)
    );

    assign m_tdata = {1'b0, taring, sat_low, sat_high, units, avg};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while the previous one was still in work");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider started while busy");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.tare_start, cmd.push, cmd.div_start, cmd.avg_load,
                  cmd.tare_step, cmd.tare_load, cmd.mul, cmd.add, cmd.fin}))
        else $error("more than one datapath command in a cycle");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:0] <= AVG_MAX))
        else $error("average above full scale");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for strain_gauge_conditioner_unit: a predictor of the filter,
// tare and calibration math checks every result request against the stream output.
// Depends on sgc_pkg and the RTL of the block under test.
`timescale 1ns / 1ps

module testbench;
    import sgc_pkg::*;

    localparam int     RING_DEPTH = 64;
    localparam longint FULL_CODE  = 4095;
    localparam int     N_PHASES   = 12;
    localparam int     PHASE_REQS = 46;

    typedef struct {
        logic        kind;
        logic [11:0] code;
    } gauge_req_t;

    typedef struct packed {
        logic [AVG_W-1:0]   avg_code;
        logic signed [31:0] units;
        logic               sat_high;
        logic               sat_low;
        logic               taring;
    } gauge_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_wr_index = '0;
    logic [CFG_DW-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;   // [11:0] sample, [15:12] zero
    logic              s_tuser = 1'b0; // kind
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;        // [19:0] avg_code, [51:20] units, [52] sat_high,
                                       // [53] sat_low, [54] taring, [55] zero

    gauge_req_t    req_fifo[$];
    gauge_result_t pending_results[$];
    int            err_count = 0;
    int            send_idle = 0;
    int            recv_idle = 0;
    bit            calm = 1'b0;

    // Predictor state and its copy of the registers.
    int unsigned win_ring [RING_DEPTH];
    longint      win_sum = 0;
    int unsigned win_pos = 0;
    int unsigned win_fill = 0;
    int unsigned win_len = 16;
    longint      avg_now = 0;
    longint      tare_val = 0;
    longint      tare_acc = 0;
    int unsigned tare_left = 0;
    int unsigned tare_cnt = 1;
    int unsigned margin = 0;
    int          slope_q = 65536;
    int          icpt_q = 0;

    strain_gauge_conditioner_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_filter();
        foreach (win_ring[i])
            win_ring[i] = 0;
        win_sum  = 0;
        win_pos  = 0;
        win_fill = 0;
        avg_now  = 0;
    endfunction

    function automatic void reg_apply(input logic [CFG_AW-1:0] idx,
                                      input logic [CFG_DW-1:0] data);
        int unsigned w;
        case (idx)
            REG_WINDOW:
            begin
                w = data[6:0];
                if (w < 1)
                    w = 1;
                if (w > RING_DEPTH)
                    w = RING_DEPTH;
                win_len = w;
                clear_filter();
            end
            REG_SLOPE:      slope_q  = int'(data);
            REG_INTERCEPT:  icpt_q   = int'(data);
            REG_TARE_COUNT: tare_cnt = data[15:0];
            REG_SAT_MARGIN: margin   = data[11:0];
            default: ;
        endcase
    endfunction

    // Works out the result that one accepted request produces.
    function automatic gauge_result_t gauge_step(input logic kind, input logic [11:0] code);
        gauge_result_t r;
        int unsigned   pos;
        longint        prod;
        longint        q;
        if (kind)
        begin
            clear_filter();
            tare_acc  = 0;
            tare_left = (tare_cnt == 0) ? 1 : tare_cnt;
        end
        else
        begin
            pos = win_pos % win_len;
            if (win_fill < win_len)
                win_fill++;
            else
                win_sum -= win_ring[pos];
            win_ring[pos] = code;
            win_sum += code;
            win_pos = (pos + 1) % win_len;
            avg_now = (win_sum << 8) / longint'(win_fill);
            if (tare_left != 0)
            begin
                tare_acc += avg_now;
                tare_left--;
                // The divisor is the register value at completion, not at tare start.
                if (tare_left == 0)
                    tare_val = (tare_acc / longint'((tare_cnt == 0) ? 1 : tare_cnt))
                               & 64'hFFFFF;
            end
        end
        prod = (avg_now - tare_val) * longint'(slope_q);
        q = (prod >>> 8) + longint'(icpt_q);
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        r.avg_code = avg_now[AVG_W-1:0];
        r.units    = q[31:0];
        r.sat_high = avg_now >= (FULL_CODE - longint'(margin)) * 256;
        r.sat_low  = avg_now <= longint'(margin) * 256;
        r.taring   = tare_left != 0;
        return r;
    endfunction

    function automatic void add_req(input logic kind, input logic [11:0] code);
        gauge_req_t q;
        q.kind = kind;
        q.code = code;
        req_fifo.push_back(q);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic wait_idle();
        while (req_fifo.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        reg_apply(idx, data);
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
    endtask

    always @(posedge clk)
    begin : req_driver
        gauge_req_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(gauge_step(s_tuser, s_tdata[11:0]));
            if (!s_tvalid || s_tready)
            begin
                if (send_idle != 0)
                begin
                    send_idle--;
                    s_tvalid <= 1'b0;
                end
                else if (req_fifo.size() != 0)
                begin
                    nxt = req_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.kind;
                    s_tdata  <= {4'b0000, nxt.code};
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_idle = $urandom_range(1, 15);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        gauge_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("avg_code", want.avg_code, m_tdata[19:0]);
                    check_field("units", want.units, $signed(m_tdata[51:20]));
                    check_field("sat_high", want.sat_high, m_tdata[52]);
                    check_field("sat_low", want.sat_low, m_tdata[53]);
                    check_field("taring", want.taring, m_tdata[54]);
                    check_field("pad bit", 0, m_tdata[55]);
                end
            end
            if (recv_idle != 0)
            begin
                recv_idle--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0)
                    recv_idle = $urandom_range(1, 15);
            end
        end
    end

    initial
    begin : sequencer
        logic [6:0]  win_w;
        logic [31:0] slope_w;
        logic [31:0] icpt_w;
        logic [15:0] tcnt_w;
        logic [11:0] marg_w;
        logic [11:0] code;
        int          level;
        int          v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset register values.
        add_req(1'b0, 12'h000);
        add_req(1'b0, 12'hFFF);
        add_req(1'b0, 12'hFFF);
        add_req(1'b0, 12'hAAA);
        add_req(1'b0, 12'h555);
        add_req(1'b1, 12'hFFF);   // tare start; its code field is ignored
        add_req(1'b0, 12'd2048);  // completes the one-sample tare
        add_req(1'b0, 12'h000);   // below the tare, so units go negative
        add_req(1'b0, 12'h001);
        add_req(1'b1, 12'h000);
        add_req(1'b1, 12'h5A5);   // tare start while already taring
        add_req(1'b0, 12'hFFE);
        add_req(1'b0, 12'hFFF);
        for (int i = 0; i < 10; i++)
            add_req(1'b0, (i % 2 != 0) ? 12'hFFF : 12'h001);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            win_w   = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 64))
                                                  : 7'($urandom_range(1, 8));
            slope_w = ($urandom_range(0, 2) == 0) ? $urandom
                                                  : 32'($urandom_range(0, 262143) - 131072);
            icpt_w  = ($urandom_range(0, 2) == 0) ? $urandom
                                                  : 32'($urandom_range(0, 2097151) - 1048576);
            tcnt_w  = 16'($urandom_range(0, 6));
            marg_w  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
            case (ph)
                0:
                begin
                    // Largest gain and offset, one-sample window, margin at full scale.
                    win_w   = 7'd1;
                    slope_w = 32'h7FFF_FFFF;
                    icpt_w  = 32'h7FFF_FFFF;
                    tcnt_w  = 16'd0;
                    marg_w  = 12'hFFF;
                end
                1:
                begin
                    win_w   = 7'd64;
                    slope_w = 32'h8000_0000;
                    icpt_w  = 32'h8000_0000;
                    tcnt_w  = 16'hFFFF;
                    marg_w  = 12'h000;
                end
                2: win_w = 7'd0;     // clamped up to one
                3: win_w = 7'd127;   // clamped down to the ring depth
                4: win_w = 7'd65;
                default: ;
            endcase
            write_reg(REG_WINDOW, {25'($urandom), win_w});
            write_reg(REG_SLOPE, slope_w);
            write_reg(REG_INTERCEPT, icpt_w);
            write_reg(REG_TARE_COUNT, {16'($urandom), tcnt_w});
            write_reg(REG_SAT_MARGIN, {20'($urandom), marg_w});
            calm  = (ph == 6) || (ph >= N_PHASES - 2);
            level = $urandom_range(0, 4095);
            for (int k = 0; k < PHASE_REQS; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    add_req(1'b1, 12'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0: code = 12'hFFF;
                        1: code = 12'h000;
                        2, 3: code = 12'($urandom);
                        default:
                        begin
                            // A steady load with a little noise around it.
                            v = level + int'($urandom_range(0, 40)) - 20;
                            code = (v < 0) ? 12'h000 : (v > 4095) ? 12'hFFF : 12'(v);
                        end
                    endcase
                    add_req(1'b0, code);
                end
            end
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
